[design/pbc_pkg.sv]
package pbc_pkg;

    // Spot sensors and lamps; fixed by the width of the spot fields.
    localparam int SPOTS          = 6;
    localparam int SPOT_W         = 6;
    localparam int COUNT_W        = 3;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int MODE_W         = 3;
    localparam int RES_W          = 2;

    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [CFG_W-1:0] AUTO_CLOSE_RESET   = 16'd4;
    localparam logic [CFG_W-1:0] MANUAL_CLOSE_RESET = 16'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CLOSE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_CLOSE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN_ENTRY  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE_ENTRY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OPEN_EXIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLOSE_EXIT  = 3'd4;

    localparam logic [RES_W-1:0] RES_NONE    = 2'd0;
    localparam logic [RES_W-1:0] RES_DONE    = 2'd1;
    localparam logic [RES_W-1:0] RES_ALREADY = 2'd2;

    typedef struct packed {
        logic               entry_open;
        logic               exit_open;
        logic               entry_manual;
        logic [COUNT_W-1:0] free_spots;
        logic [SPOT_W-1:0]  spot_lamps;
        logic [RES_W-1:0]   command_result;
    } t_result;

endpackage

[design/pbc_tick.sv]
module pbc_tick #(
    parameter int TIMER_BITS = pbc_pkg::TIMER_BITS_DEF
) (
    input  logic [pbc_pkg::MODE_W-1:0] i_mode,
    input  logic [pbc_pkg::SPOT_W-1:0] i_spots,
    input  logic                       i_car_in,
    input  logic                       i_car_out,
    input  logic [pbc_pkg::CFG_W-1:0]  i_auto_lim,
    input  logic [pbc_pkg::CFG_W-1:0]  i_manual_lim,
    input  logic                       i_entry_open,
    input  logic                       i_entry_by_cmd,
    input  logic [TIMER_BITS-1:0]      i_entry_el,
    input  logic                       i_exit_open,
    input  logic [TIMER_BITS-1:0]      i_exit_el,
    output logic                       o_entry_open,
    output logic                       o_entry_by_cmd,
    output logic [TIMER_BITS-1:0]      o_entry_el,
    output logic                       o_exit_open,
    output logic [TIMER_BITS-1:0]      o_exit_el,
    output pbc_pkg::t_result           o_result
);

    localparam int CMP_W = (TIMER_BITS > pbc_pkg::CFG_W) ? TIMER_BITS : pbc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [pbc_pkg::CFG_W-1:0]   entry_lim;
    logic                        entry_exp;
    logic                        exit_exp;
    logic [pbc_pkg::SPOT_W-1:0]  spots_m;
    logic [pbc_pkg::COUNT_W-1:0] cnt;
    logic [pbc_pkg::RES_W-1:0]   res;
    logic                        en_open;
    logic                        en_cmd;
    logic [TIMER_BITS-1:0]       en_el;
    logic                        ex_open;
    logic [TIMER_BITS-1:0]       ex_el;

    assign entry_lim = i_entry_by_cmd ? i_manual_lim : i_auto_lim;
    // a count stuck at the counter maximum counts as expired
    assign entry_exp = (CMP_W'(i_entry_el) >= CMP_W'(entry_lim)) || (i_entry_el == TMAX);
    assign exit_exp  = (CMP_W'(i_exit_el) >= CMP_W'(i_auto_lim)) || (i_exit_el == TMAX);

    always_comb begin
        spots_m = '0;
        cnt     = '0;
        for (int i = 0; i < pbc_pkg::SPOTS; i++) begin
            spots_m[i] = i_spots[i];
            cnt        = cnt + pbc_pkg::COUNT_W'(i_spots[i]);
        end
    end

    always_comb begin
        en_open = i_entry_open;
        en_cmd  = i_entry_by_cmd;
        en_el   = i_entry_el;
        ex_open = i_exit_open;
        ex_el   = i_exit_el;
        res     = pbc_pkg::RES_NONE;

        // timers first, then auto open
        if (i_entry_open) begin
            if (entry_exp) begin
                if (!i_car_in) begin
                    en_open = 1'b0;
                end else begin
                    en_el = '0;
                end
            end else begin
                en_el = i_entry_el + TIMER_BITS'(1);
            end
        end else if (i_car_in) begin
            en_open = 1'b1;
            en_cmd  = 1'b0;
            en_el   = '0;
        end

        if (i_exit_open) begin
            if (exit_exp) begin
                if (!i_car_out) begin
                    ex_open = 1'b0;
                end else begin
                    ex_el = '0;
                end
            end else begin
                ex_el = i_exit_el + TIMER_BITS'(1);
            end
        end else if (i_car_out) begin
            ex_open = 1'b1;
            ex_el   = '0;
        end

        // command acts on the state after the automatic logic
        case (i_mode)
            pbc_pkg::MODE_OPEN_ENTRY: begin
                if (!en_open) begin
                    en_open = 1'b1;
                    en_cmd  = 1'b1;
                    en_el   = '0;
                    res     = pbc_pkg::RES_DONE;
                end else begin
                    res = pbc_pkg::RES_ALREADY;
                end
            end
            pbc_pkg::MODE_CLOSE_ENTRY: begin
                if (en_open) begin
                    en_open = 1'b0;
                    res     = pbc_pkg::RES_DONE;
                end else begin
                    res = pbc_pkg::RES_ALREADY;
                end
            end
            pbc_pkg::MODE_OPEN_EXIT: begin
                if (!ex_open) begin
                    ex_open = 1'b1;
                    ex_el   = '0;
                    res     = pbc_pkg::RES_DONE;
                end else begin
                    res = pbc_pkg::RES_ALREADY;
                end
            end
            pbc_pkg::MODE_CLOSE_EXIT: begin
                if (ex_open) begin
                    ex_open = 1'b0;
                    res     = pbc_pkg::RES_DONE;
                end else begin
                    res = pbc_pkg::RES_ALREADY;
                end
            end
            default: begin
                res = pbc_pkg::RES_NONE;
            end
        endcase
    end

    assign o_entry_open   = en_open;
    assign o_entry_by_cmd = en_cmd;
    assign o_entry_el     = en_el;
    assign o_exit_open    = ex_open;
    assign o_exit_el      = ex_el;

    assign o_result.entry_open     = en_open;
    assign o_result.exit_open      = ex_open;
    assign o_result.entry_manual   = en_cmd;
    assign o_result.free_spots     = cnt;
    assign o_result.spot_lamps     = spots_m;
    assign o_result.command_result = res;

endmodule

[design/parking_barrier_controller_unit.sv]
// Parking barrier controller. Each input beat is one sensor sample: spot free
// bits, car-present bits at both gates and an optional gate command. Each
// sample yields exactly one output beat with barrier states, the command
// outcome, the free-spot count and the lamp drive. A beat is accepted every
// clock and passes the input register, then the result register; the state
// update of both gate timers sets that rate. Output backpressure stalls the
// input only once both registers hold a beat. The user must write close
// limits through the cfg port while the block is idle; it is not enforced.
module parking_barrier_controller_unit #(
    parameter int TIMER_BITS = pbc_pkg::TIMER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pbc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [2:0] mode, [8:3] spot_free_bits, [9] car_at_entry, [10] car_at_exit
    input  logic [pbc_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] entry_open, [1] exit_open, [2] entry_manual, [5:3] free_spots,
    // [11:6] spot_lamps, [13:12] command_result
    output logic [pbc_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    logic [pbc_pkg::CFG_W-1:0]  r_auto_lim;
    logic [pbc_pkg::CFG_W-1:0]  r_manual_lim;

    logic                       r_in_valid;
    logic [pbc_pkg::MODE_W-1:0] r_in_mode;
    logic [pbc_pkg::SPOT_W-1:0] r_in_spots;
    logic                       r_in_car_in;
    logic                       r_in_car_out;

    logic                       r_entry_open;
    logic                       r_entry_by_cmd;
    logic [TIMER_BITS-1:0]      r_entry_el;
    logic                       r_exit_open;
    logic [TIMER_BITS-1:0]      r_exit_el;

    logic                       r_out_valid;
    pbc_pkg::t_result           r_out;

    logic                       n_entry_open;
    logic                       n_entry_by_cmd;
    logic [TIMER_BITS-1:0]      n_entry_el;
    logic                       n_exit_open;
    logic [TIMER_BITS-1:0]      n_exit_el;
    pbc_pkg::t_result           n_out;

    logic                       s_accept;
    logic                       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_lim   <= pbc_pkg::AUTO_CLOSE_RESET;
            r_manual_lim <= pbc_pkg::MANUAL_CLOSE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbc_pkg::CFG_AUTO_CLOSE:   r_auto_lim   <= i_cfg_data;
                pbc_pkg::CFG_MANUAL_CLOSE: r_manual_lim <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_mode    <= i_s_tdata[2:0];
            r_in_spots   <= i_s_tdata[8:3];
            r_in_car_in  <= i_s_tdata[9];
            r_in_car_out <= i_s_tdata[10];
        end
    end

    pbc_tick #(
        .TIMER_BITS (TIMER_BITS)
    ) u_tick (
        .i_mode         (r_in_mode),
        .i_spots        (r_in_spots),
        .i_car_in       (r_in_car_in),
        .i_car_out      (r_in_car_out),
        .i_auto_lim     (r_auto_lim),
        .i_manual_lim   (r_manual_lim),
        .i_entry_open   (r_entry_open),
        .i_entry_by_cmd (r_entry_by_cmd),
        .i_entry_el     (r_entry_el),
        .i_exit_open    (r_exit_open),
        .i_exit_el      (r_exit_el),
        .o_entry_open   (n_entry_open),
        .o_entry_by_cmd (n_entry_by_cmd),
        .o_entry_el     (n_entry_el),
        .o_exit_open    (n_exit_open),
        .o_exit_el      (n_exit_el),
        .o_result       (n_out)
    );

    // gate state commits together with the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_open   <= 1'b0;
            r_entry_by_cmd <= 1'b0;
            r_entry_el     <= '0;
            r_exit_open    <= 1'b0;
            r_exit_el      <= '0;
        end else if (advance) begin
            r_entry_open   <= n_entry_open;
            r_entry_by_cmd <= n_entry_by_cmd;
            r_entry_el     <= n_entry_el;
            r_exit_open    <= n_exit_open;
            r_exit_el      <= n_exit_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00,
                         r_out.command_result,
                         r_out.spot_lamps,
                         r_out.free_spots,
                         r_out.entry_manual,
                         r_out.exit_open,
                         r_out.entry_open};

`ifndef NO_ASSERTIONS
    // the pending beat always reflects the current gate state
    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.entry_open == r_entry_open &&
                         r_out.exit_open == r_exit_open &&
                         r_out.entry_manual == r_entry_by_cmd))
        else $error("output beat disagrees with gate state");

    a_count_matches_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'($countones(r_out.spot_lamps)) == 32'(r_out.free_spots)))
        else $error("free spot count disagrees with lamps");

    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_mode) &&
                                      $stable(r_in_spots)))
        else $error("input register lost a stalled beat");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled with room available");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pbc_pkg::*;

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_CFG,
        OP_DRAIN,
        OP_PACE
    } t_stim_kind;

    typedef struct {
        t_stim_kind            kind;
        logic [IN_TDATA_W-1:0] beat;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      val;
        int                    send_pct;
        int                    recv_pct;
    } t_stim_op;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [2:0] mode, [8:3] spot_free_bits, [9] car_at_entry, [10] car_at_exit
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [0] entry_open, [1] exit_open, [2] entry_manual, [5:3] free_spots,
    // [11:6] spot_lamps, [13:12] command_result
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    parking_barrier_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    t_stim_op stim_q[$];
    t_result  gate_state_q[$];
    int       beats_sent = 0;
    int       beats_back = 0;
    int       quiet_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       fail_cnt = 0;

    // barrier model state
    logic [CFG_W-1:0] lim_auto = AUTO_CLOSE_RESET;
    logic [CFG_W-1:0] lim_manual = MANUAL_CLOSE_RESET;
    logic             entry_up = 1'b0;
    logic             entry_cmd = 1'b0;
    logic [CFG_W-1:0] entry_cnt = '0;
    logic             exit_up = 1'b0;
    logic [CFG_W-1:0] exit_cnt = '0;

    // sticky car sensors for the random part
    logic car_in_q = 1'b0;
    logic car_out_q = 1'b0;

    function automatic t_result barrier_tick(logic [IN_TDATA_W-1:0] beat);
        t_result          r;
        logic [2:0]       mode;
        logic [SPOT_W-1:0] spots;
        logic             car_in;
        logic             car_out;
        logic [CFG_W-1:0] lim;
        mode    = beat[2:0];
        spots   = beat[8:3];
        car_in  = beat[9];
        car_out = beat[10];
        r.command_result = RES_NONE;

        if (entry_up) begin
            lim = entry_cmd ? lim_manual : lim_auto;
            if (entry_cnt >= lim || entry_cnt == '1) begin
                if (!car_in)
                    entry_up = 1'b0;
                else
                    entry_cnt = '0;
            end else begin
                entry_cnt = entry_cnt + 1'b1;
            end
        end else if (car_in) begin
            entry_up  = 1'b1;
            entry_cmd = 1'b0;
            entry_cnt = '0;
        end

        if (exit_up) begin
            if (exit_cnt >= lim_auto || exit_cnt == '1) begin
                if (!car_out)
                    exit_up = 1'b0;
                else
                    exit_cnt = '0;
            end else begin
                exit_cnt = exit_cnt + 1'b1;
            end
        end else if (car_out) begin
            exit_up  = 1'b1;
            exit_cnt = '0;
        end

        case (mode)
            MODE_OPEN_ENTRY: begin
                if (!entry_up) begin
                    entry_up  = 1'b1;
                    entry_cmd = 1'b1;
                    entry_cnt = '0;
                    r.command_result = RES_DONE;
                end else begin
                    r.command_result = RES_ALREADY;
                end
            end
            MODE_CLOSE_ENTRY: begin
                r.command_result = entry_up ? RES_DONE : RES_ALREADY;
                entry_up = 1'b0;
            end
            MODE_OPEN_EXIT: begin
                if (!exit_up) begin
                    exit_up  = 1'b1;
                    exit_cnt = '0;
                    r.command_result = RES_DONE;
                end else begin
                    r.command_result = RES_ALREADY;
                end
            end
            MODE_CLOSE_EXIT: begin
                r.command_result = exit_up ? RES_DONE : RES_ALREADY;
                exit_up = 1'b0;
            end
            default: r.command_result = RES_NONE;
        endcase

        r.entry_open   = entry_up;
        r.exit_open    = exit_up;
        r.entry_manual = entry_cmd;
        r.free_spots   = COUNT_W'($countones(spots));
        r.spot_lamps   = spots;
        return r;
    endfunction

    task automatic add_beat(logic [2:0] mode, logic [SPOT_W-1:0] spots,
                            logic car_in, logic car_out);
        t_stim_op op;
        op.kind = OP_BEAT;
        op.beat = {5'd0, car_out, car_in, spots, mode};
        stim_q.push_back(op);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_stim_op op;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.val  = val;
        stim_q.push_back(op);
    endtask

    task automatic add_ctrl(t_stim_kind kind, int send_pct, int recv_pct);
        t_stim_op op;
        op.kind     = kind;
        op.send_pct = send_pct;
        op.recv_pct = recv_pct;
        stim_q.push_back(op);
    endtask

    // cars arrive and linger for a while; commands are sparse
    task automatic add_traffic(int n);
        int         r;
        logic [2:0] mode;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 12)
                car_in_q = ~car_in_q;
            if ($urandom_range(0, 99) < 12)
                car_out_q = ~car_out_q;
            r = $urandom_range(0, 99);
            if (r < 65)
                mode = MODE_NONE;
            else if (r < 95)
                mode = 3'($urandom_range(MODE_OPEN_ENTRY, MODE_CLOSE_EXIT));
            else
                mode = 3'($urandom_range(5, 7));
            add_beat(mode, SPOT_W'($urandom_range(0, 63)), car_in_q, car_out_q);
        end
    endtask

    // stimulus driver and config writer
    always @(posedge i_clk) begin : drive_proc
        logic                  nv;
        logic [IN_TDATA_W-1:0] nd;
        logic                  nwe;
        logic [CFG_IDX_W-1:0]  nidx;
        logic [CFG_W-1:0]      ncfg;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_cfg_we   <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            nv   = i_s_tvalid;
            nd   = i_s_tdata;
            nwe  = 1'b0;
            nidx = i_cfg_index;
            ncfg = i_cfg_data;
            if (i_s_tvalid && o_s_tready) begin
                beats_sent++;
                nv = 1'b0;
            end
            if (o_m_tvalid && i_m_tready)
                beats_back++;
            if (!i_s_tvalid && !i_cfg_we && beats_sent == beats_back)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!nv && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    OP_PACE: begin
                        send_idle_pct = stim_q[0].send_pct;
                        recv_idle_pct = stim_q[0].recv_pct;
                        void'(stim_q.pop_front());
                    end
                    OP_BEAT: begin
                        if ($urandom_range(0, 99) >= send_idle_pct) begin
                            nv = 1'b1;
                            nd = stim_q[0].beat;
                            void'(stim_q.pop_front());
                        end
                    end
                    OP_DRAIN: begin
                        if (beats_sent == beats_back)
                            void'(stim_q.pop_front());
                    end
                    OP_CFG: begin
                        // let the pipeline empty and leave margin before a write
                        if (quiet_cycles >= 4) begin
                            nwe  = 1'b1;
                            nidx = stim_q[0].idx;
                            ncfg = stim_q[0].val;
                            quiet_cycles = 0;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: void'(stim_q.pop_front());
                endcase
            end

            i_s_tvalid  <= nv;
            i_s_tdata   <= nd;
            i_cfg_we    <= nwe;
            i_cfg_index <= nidx;
            i_cfg_data  <= ncfg;
            i_m_tready  <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // predictor and result checker
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_AUTO_CLOSE)
                    lim_auto = i_cfg_data;
                else if (i_cfg_index == CFG_MANUAL_CLOSE)
                    lim_manual = i_cfg_data;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.entry_open     = o_m_tdata[0];
                got.exit_open      = o_m_tdata[1];
                got.entry_manual   = o_m_tdata[2];
                got.free_spots     = o_m_tdata[5:3];
                got.spot_lamps     = o_m_tdata[11:6];
                got.command_result = o_m_tdata[13:12];
                if (gate_state_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: unexpected result beat %h", $realtime, o_m_tdata);
                    fail_cnt++;
                end else begin
                    want = gate_state_q.pop_front();
                    if (got.entry_open !== want.entry_open ||
                        got.exit_open !== want.exit_open ||
                        got.entry_manual !== want.entry_manual ||
                        got.free_spots !== want.free_spots ||
                        got.spot_lamps !== want.spot_lamps ||
                        got.command_result !== want.command_result) begin
                        if (fail_cnt < 10) begin
                            $write("%0t: mismatch entry %b/%b exit %b/%b manual %b/%b ",
                                   $realtime, want.entry_open, got.entry_open,
                                   want.exit_open, got.exit_open,
                                   want.entry_manual, got.entry_manual);
                            $display("free %0d/%0d lamps %h/%h cmd %0d/%0d (exp/act)",
                                     want.free_spots, got.free_spots,
                                     want.spot_lamps, got.spot_lamps,
                                     want.command_result, got.command_result);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                gate_state_q.push_back(barrier_tick(i_s_tdata));
        end
    end

    initial begin
        // directed part, reset limits (auto 4, manual 20)
        add_ctrl(OP_PACE, 38, 52);
        add_beat(MODE_NONE, 6'h00, 1'b0, 1'b0);
        add_beat(MODE_NONE, 6'h3F, 1'b0, 1'b0);
        add_beat(MODE_NONE, 6'h15, 1'b0, 1'b0);
        add_beat(MODE_OPEN_ENTRY, 6'h2A, 1'b0, 1'b0);
        add_beat(MODE_OPEN_ENTRY, 6'h01, 1'b0, 1'b0);
        add_beat(MODE_CLOSE_ENTRY, 6'h20, 1'b0, 1'b0);
        add_beat(MODE_CLOSE_ENTRY, 6'h3F, 1'b0, 1'b0);
        add_beat(MODE_OPEN_EXIT, 6'h00, 1'b0, 1'b0);
        add_beat(MODE_OPEN_EXIT, 6'h0F, 1'b0, 1'b0);
        add_beat(MODE_CLOSE_EXIT, 6'h30, 1'b0, 1'b0);
        add_beat(MODE_CLOSE_EXIT, 6'h00, 1'b0, 1'b0);
        add_beat(3'd5, 6'h3F, 1'b0, 1'b0);
        add_beat(3'd6, 6'h12, 1'b0, 1'b0);
        add_beat(3'd7, 6'h2D, 1'b0, 1'b0);
        // cars held past the limit: timers restart instead of closing
        for (int k = 0; k < 7; k++)
            add_beat(MODE_NONE, 6'h3F, 1'b1, 1'b1);
        for (int k = 0; k < 6; k++)
            add_beat(MODE_NONE, 6'h00, 1'b0, 1'b0);

        add_cfg(CFG_AUTO_CLOSE, 16'd1);
        add_cfg(CFG_MANUAL_CLOSE, 16'hFFFF);
        add_traffic(200);
        add_ctrl(OP_DRAIN, 0, 0);
        add_traffic(200);

        add_ctrl(OP_PACE, 52, 38);
        add_cfg(CFG_AUTO_CLOSE, 16'hFFFF);
        add_cfg(CFG_MANUAL_CLOSE, 16'd1);
        add_traffic(400);

        // zero limits expire on the first tick after opening
        add_ctrl(OP_PACE, 0, 0);
        add_cfg(CFG_AUTO_CLOSE, 16'd0);
        add_cfg(CFG_MANUAL_CLOSE, 16'd0);
        add_beat(MODE_OPEN_ENTRY, 6'h01, 1'b0, 1'b0);
        add_beat(MODE_NONE, 6'h02, 1'b0, 1'b0);
        add_beat(MODE_NONE, 6'h04, 1'b1, 1'b1);
        add_beat(MODE_NONE, 6'h08, 1'b1, 1'b1);
        add_beat(MODE_NONE, 6'h10, 1'b0, 1'b0);
        add_traffic(150);

        add_cfg(CFG_AUTO_CLOSE, 16'd3);
        add_cfg(CFG_MANUAL_CLOSE, 16'd7);
        add_traffic(600);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #1;
        end while (stim_q.size() != 0 || i_s_tvalid || beats_sent != beats_back);
        repeat (10) @(posedge i_clk);

        if (gate_state_q.size() != 0) begin
            $display("%0d expected result beats never arrived", gate_state_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
